// ===== design/sync_length_frame_deframer_macros.svh =====
// Assertion macros shared by the deframer checker.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SLFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SLFD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/slfd_pkg.sv =====
// Types, codes and fixed constants of the sync-word frame deframer.
package slfd_pkg;

    localparam int MAX_BODY    = 4096;
    localparam int MAX_TRAILER = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LENGTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BYTES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIG_ENDIAN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BODY          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_BYTES     = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_NEED_MORE  = 2'd0;
    localparam logic [1:0] ST_FRAME_DONE = 2'd1;
    localparam logic [1:0] ST_RESYNC     = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_BODY    = 2'd1;
    localparam logic [1:0] KIND_TRAILER = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_BODY,
        PH_TRAILER
    } phase_t;

    typedef struct packed {
        logic [63:0] sync_pattern;
        logic [3:0]  sync_length;
        logic [3:0]  length_bytes;
        logic        length_big_endian;
        logic [12:0] min_body;
        logic [12:0] max_body;
        logic [3:0]  trailer_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       sync_hit;
    } queue_entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [11:0] position;
        logic [12:0] frame_length;
    } result_t;

    function automatic logic [3:0] clamp_trailer(input logic [3:0] v);
        clamp_trailer = (v > 4'(MAX_TRAILER)) ? 4'(MAX_TRAILER) : v;
    endfunction

endpackage

// ===== design/slfd_front.sv =====
// Front end: accepts bytes, keeps the sync window and flags sync matches.
module slfd_front
    import slfd_pkg::*;
#(
    parameter int MAX_SYNC = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         in_valid,
    input  logic [7:0]   in_data,
    input  logic         queue_ready,
    output logic         in_ready,
    output logic         push,
    output queue_entry_t entry
);

    localparam int WIN_W  = 8 * MAX_SYNC;
    localparam int FILL_W = $clog2(MAX_SYNC + 1);

    logic [WIN_W-1:0]  window_reg, window_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [3:0]        sync_n;
    logic [MAX_SYNC-1:0] byte_ok;

    assign in_ready = queue_ready;
    assign push     = in_valid & queue_ready;

    assign window_next = WIN_W'({window_reg, in_data});
    assign fill_next   = (fill_reg == FILL_W'(MAX_SYNC)) ? fill_reg : fill_reg + FILL_W'(1);

    always_comb begin
        if (cfg.sync_length == 4'd0) begin
            sync_n = 4'd1;
        end else if (cfg.sync_length > 4'(MAX_SYNC)) begin
            sync_n = 4'(MAX_SYNC);
        end else begin
            sync_n = cfg.sync_length;
        end
    end

    // Bytes beyond the configured sync length always compare equal.
    always_comb begin
        for (int i = 0; i < MAX_SYNC; i++) begin
            byte_ok[i] = (window_next[8*i +: 8] == cfg.sync_pattern[8*i +: 8]) ||
                         (4'(i) >= sync_n);
        end
    end

    assign entry.data     = in_data;
    assign entry.sync_hit = (&byte_ok) && (4'(fill_next) >= sync_n);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            fill_reg   <= '0;
        end else if (push) begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== design/slfd_queue.sv =====
// Short queue between the classifying front end and the frame sequencer.
module slfd_queue
    import slfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output logic         not_full,
    output logic         not_empty,
    output queue_entry_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/slfd_back.sv =====
// Back end: frame sequencer that parses length, body and trailer per byte.
module slfd_back
    import slfd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  queue_entry_t q_entry,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output result_t      m_result
);

    localparam int LEN_W = 8 * MAX_LENGTH_BYTES;
    localparam int CMP_W = (LEN_W > 17) ? LEN_W : 17;

    phase_t            phase_reg, phase_next;
    logic [12:0]       count_reg, count_next;
    logic [LEN_W-1:0]  accum_reg, accum_next;
    logic [12:0]       body_len_reg, body_len_next;
    logic              out_valid_reg;
    result_t           out_reg, res_next;

    logic              take;
    logic [7:0]        b;
    logic [3:0]        len_n, trail_n;
    logic [12:0]       count_inc;
    logic [LEN_W-1:0]  accum_new;
    logic              len_done, len_bad, len_zero;
    logic              body_done, trail_none, trail_done;

    assign take  = q_valid & (~out_valid_reg | m_ready);
    assign q_pop = take;
    assign b     = q_entry.data;

    always_comb begin
        if (cfg.length_bytes == 4'd0) begin
            len_n = 4'd1;
        end else if (cfg.length_bytes > 4'(MAX_LENGTH_BYTES)) begin
            len_n = 4'(MAX_LENGTH_BYTES);
        end else begin
            len_n = cfg.length_bytes;
        end
    end

    assign trail_n    = clamp_trailer(cfg.trailer_bytes);
    assign trail_none = (trail_n == 4'd0);
    assign count_inc  = count_reg + 13'd1;

    // Little-endian bytes land at the position given by the byte count.
    assign accum_new = cfg.length_big_endian ? LEN_W'({accum_reg, b})
                     : (accum_reg | (LEN_W'(b) << {count_reg, 3'b000}));

    assign len_done   = (count_inc >= {9'd0, len_n});
    assign len_bad    = (CMP_W'(accum_new) < CMP_W'(cfg.min_body)) ||
                        (CMP_W'(accum_new) > CMP_W'(cfg.max_body)) ||
                        (CMP_W'(accum_new) > CMP_W'(MAX_BODY));
    assign len_zero   = (accum_new == '0);
    assign body_done  = (count_inc >= body_len_reg);
    assign trail_done = (count_inc >= {9'd0, trail_n});

    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (q_entry.sync_hit) begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (len_done) begin
                        if (len_bad) begin
                            phase_next = PH_HUNT;
                        end else if (len_zero) begin
                            phase_next = trail_none ? PH_HUNT : PH_TRAILER;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (body_done) begin
                        phase_next = trail_none ? PH_HUNT : PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    if (trail_done) begin
                        phase_next = PH_HUNT;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        count_next    = count_reg;
        accum_next    = accum_reg;
        body_len_next = body_len_reg;
        res_next      = '0;
        if (take) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (q_entry.sync_hit) begin
                        count_next = '0;
                        accum_next = '0;
                    end
                end
                PH_LENGTH: begin
                    if (!len_done) begin
                        count_next = count_inc;
                        accum_next = accum_new;
                    end else if (len_bad) begin
                        count_next      = '0;
                        accum_next      = '0;
                        body_len_next   = '0;
                        res_next.status = ST_RESYNC;
                    end else begin
                        count_next    = '0;
                        accum_next    = accum_new;
                        body_len_next = 13'(accum_new);
                        if (len_zero && trail_none) begin
                            res_next.status = ST_FRAME_DONE;
                        end
                    end
                end
                PH_BODY: begin
                    res_next.kind     = KIND_BODY;
                    res_next.data     = b;
                    res_next.position = count_reg[11:0];
                    if (body_done) begin
                        count_next = '0;
                        if (trail_none) begin
                            res_next.status = ST_FRAME_DONE;
                        end
                    end else begin
                        count_next = count_inc;
                    end
                end
                PH_TRAILER: begin
                    res_next.kind     = KIND_TRAILER;
                    res_next.data     = b;
                    res_next.position = count_reg[11:0];
                    if (trail_done) begin
                        count_next      = '0;
                        res_next.status = ST_FRAME_DONE;
                    end else begin
                        count_next = count_inc;
                    end
                end
                default: count_next = '0;
            endcase
        end
        res_next.frame_length = body_len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            accum_reg     <= '0;
            body_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            accum_reg    <= accum_next;
            body_len_reg <= body_len_next;
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= res_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ===== design/sync_length_frame_deframer.sv =====
// Top level of the sync-word, length-prefixed frame deframer.
//
// One received byte enters per cycle on the slave stream and each byte yields
// exactly one result transaction on the master stream, so the sustained rate is
// one byte per clock while m_tready is high; a result is registered after its
// byte has passed through the queue. The front end shifts every byte into the
// sync window and compares it against the sync word in parallel, a two-entry
// queue decouples it from the frame sequencer, and the sequencer handles the
// length field, body and trailer in a combinational update per byte that feeds
// a registered output. The window is never cleared on resync. Trailer bytes are
// tagged, not checked. There is no clearing pass after reset. Configuration
// must only be written while no transaction is in flight and must be valid.
module sync_length_frame_deframer
    import slfd_pkg::*;
#(
    parameter int MAX_SYNC         = 8,
    parameter int MAX_LENGTH_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] data, [19:8] position,
                                             // [32:20] frame_length, rest zero
    output logic [M_TUSER_W-1:0]  m_tuser,   // [1:0] status, [3:2] kind
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t         cfg_reg;
    logic         q_push, q_pop, q_not_full, q_not_empty;
    queue_entry_t push_entry, head_entry;
    result_t      result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_pattern      <= 64'd0;
            cfg_reg.sync_length       <= 4'd1;
            cfg_reg.length_bytes      <= 4'd1;
            cfg_reg.length_big_endian <= 1'b1;
            cfg_reg.min_body          <= 13'd0;
            cfg_reg.max_body          <= 13'd4096;
            cfg_reg.trailer_bytes     <= 4'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SYNC_PATTERN:      cfg_reg.sync_pattern      <= cfg_wdata;
                CFG_SYNC_LENGTH:       cfg_reg.sync_length       <= cfg_wdata[3:0];
                CFG_LENGTH_BYTES:      cfg_reg.length_bytes      <= cfg_wdata[3:0];
                CFG_LENGTH_BIG_ENDIAN: cfg_reg.length_big_endian <= cfg_wdata[0];
                CFG_MIN_BODY:          cfg_reg.min_body          <= cfg_wdata[12:0];
                CFG_MAX_BODY:          cfg_reg.max_body          <= cfg_wdata[12:0];
                CFG_TRAILER_BYTES:     cfg_reg.trailer_bytes     <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    slfd_front #(
        .MAX_SYNC (MAX_SYNC)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_data     (s_tdata[7:0]),
        .queue_ready (q_not_full),
        .in_ready    (s_tready),
        .push        (q_push),
        .entry       (push_entry)
    );

    slfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .not_full   (q_not_full),
        .not_empty  (q_not_empty),
        .head       (head_entry)
    );

    slfd_back #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_not_empty),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {7'd0, result.frame_length, result.position, result.data};
    assign m_tuser = {result.kind, result.status};

endmodule

// ===== design/slfd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
`include "sync_length_frame_deframer_macros.svh"

module slfd_checker
    import slfd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result must hold its contents.
    `SLFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Results without a payload byte carry zero data and position.
    `SLFD_ASSERT_IMPLY(a_no_payload_zero, aclk, aresetn, m_tvalid && (m_tuser[3:2] == KIND_NONE), m_tdata[19:0] == 20'd0, "empty result carries data")

    // A bad length clears the frame length and carries no byte.
    `SLFD_ASSERT_IMPLY(a_resync_clean, aclk, aresetn, m_tvalid && (m_tuser[1:0] == ST_RESYNC), (m_tdata[32:20] == 13'd0) && (m_tuser[3:2] == KIND_NONE), "resync result not clean")

    // Nothing is offered right after reset.
    `SLFD_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind sync_length_frame_deframer slfd_checker u_slfd_checker (.*);
